// ----- rtl/plc_pkg.sv -----
`default_nettype none

package plc_pkg;

   // operation broadcast to every cell of the chain
   typedef logic [2:0] cell_op_type;

   localparam cell_op_type CELL_HOLD   = 3'd0;
   localparam cell_op_type CELL_INSERT = 3'd1; // open a gap at pos, fill it
   localparam cell_op_type CELL_REMOVE = 3'd2; // close the gap at pos
   localparam cell_op_type CELL_WRITE  = 3'd3; // overwrite the entry at pos
   localparam cell_op_type CELL_ROTATE = 3'd4; // one step left, head wraps to pos

   // command kinds on req_kind; 11 to 15 are spare and ignored
   localparam logic [3:0] K_PUSH_FRONT = 4'd0;
   localparam logic [3:0] K_PUSH_BACK  = 4'd1;
   localparam logic [3:0] K_INSERT     = 4'd2;
   localparam logic [3:0] K_POP_FRONT  = 4'd3;
   localparam logic [3:0] K_POP_BACK   = 4'd4;
   localparam logic [3:0] K_REMOVE     = 4'd5;
   localparam logic [3:0] K_READ       = 4'd6;
   localparam logic [3:0] K_SWAP       = 4'd7;
   localparam logic [3:0] K_ROTATE     = 4'd8;
   localparam logic [3:0] K_COLLIDE    = 4'd9;
   localparam logic [3:0] K_CLEAR      = 4'd10;

   // status codes on rsp_status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/plc_cell.sv -----
`default_nettype none

module plc_cell #(
   parameter int CAPACITY   = 256,
   parameter int COORD_BITS = 16
) (
   input  wire                                   clock,
   input  wire  [$clog2(CAPACITY)-1:0]           my_index,
   input  wire  plc_pkg::cell_op_type            op,
   input  wire  [$clog2(CAPACITY)-1:0]           pos,
   input  wire  [$clog2(CAPACITY+1)-1:0]         occ,
   input  wire  [2*COORD_BITS-1:0]               data,
   input  wire  [2*COORD_BITS-1:0]               prev_pt,
   input  wire  [2*COORD_BITS-1:0]               next_pt,
   input  wire  [2*COORD_BITS-1:0]               head_pt,
   input  wire  [2*COORD_BITS-1:0]               next_pass_pt,
   input  wire                                   next_pass_hit,
   output logic [2*COORD_BITS-1:0]               pt,
   output logic [2*COORD_BITS-1:0]               pass_pt,
   output logic                                  pass_hit
);
   import plc_pkg::*;

   localparam int OW = $clog2(CAPACITY + 1);

   logic [2*COORD_BITS-1:0] pt_ff, pt_in;
   logic [2*COORD_BITS-1:0] pass_pt_ff, pass_pt_in;
   logic                    pass_hit_ff, pass_hit_in;
   logic                    valid;

   assign valid = OW'(my_index) < occ;

   always_comb begin
      pt_in = pt_ff;
      unique case (op)
         CELL_INSERT: begin
            if (my_index > pos) begin
               pt_in = prev_pt;
            end else if (my_index == pos) begin
               pt_in = data;
            end
         end
         CELL_REMOVE: begin
            if (my_index >= pos) begin
               pt_in = next_pt;
            end
         end
         CELL_WRITE: begin
            if (my_index == pos) begin
               pt_in = data;
            end
         end
         CELL_ROTATE: begin
            if (my_index < pos) begin
               pt_in = next_pt;
            end else if (my_index == pos) begin
               pt_in = head_pt;
            end
         end
         default: pt_in = pt_ff;
      endcase
   end

   // search wave towards the head: selected entry and running match flag
   assign pass_pt_in  = (my_index == pos) ? pt_ff : next_pass_pt;
   assign pass_hit_in = (valid && (pt_ff == data)) || next_pass_hit;

   always_ff @(posedge clock) begin
      pt_ff       <= pt_in;
      pass_pt_ff  <= pass_pt_in;
      pass_hit_ff <= pass_hit_in;
   end

   assign pt       = pt_ff;
   assign pass_pt  = pass_pt_ff;
   assign pass_hit = pass_hit_ff;

endmodule

`default_nettype wire

// ----- rtl/point_list_with_collision.sv -----
// Channel     Ports                                         Transaction
// command     start, busy, req_kind/index/index_b/x/y       taken when start & !busy
// result      rsp_strobe, rsp_status/point_x/point_y/       one cycle, strobe high,
//             rsp_hit/rsp_count                             no back-pressure
//
// One command in flight at a time; busy is high from acceptance until the
// result cycle has passed. Rejected commands, clear and spare kinds go
// straight to the result; push and insert open a gap; read and collide
// run the search wave; pop and remove run it, then close the gap; rotate
// by r steps the chain r times, once a cycle; swap runs the wave twice,
// then writes both slots. The wave walks the chain to the head, one cell a cycle.
// Synchronous active-high reset empties the list; cell contents are not
// cleared. The receiver cannot stall: each result shows for one cycle.
`default_nettype none

module point_list_with_collision #(
   parameter int CAPACITY   = 256,
   parameter int COORD_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [3:0]         req_kind,
   input  wire  [7:0]         req_index,
   input  wire  [7:0]         req_index_b,
   input  wire  signed [15:0] req_x,
   input  wire  signed [15:0] req_y,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_point_x,
   output logic signed [15:0] rsp_point_y,
   output logic               rsp_hit,
   output logic [8:0]         rsp_count
);
   import plc_pkg::*;

   localparam int PW = $clog2(CAPACITY);        // position width
   localparam int OW = $clog2(CAPACITY + 1);    // occupancy width
   localparam int CW = (OW > 8) ? OW : 8;       // width for range checks and counter
   localparam int CB = COORD_BITS;
   localparam int PB = 2 * COORD_BITS;          // one point: x high, y low

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;   // search wave running
   localparam logic [2:0] S_TAKE  = 3'd2;   // wave result at the head
   localparam logic [2:0] S_SHIFT = 3'd3;   // open or close a gap
   localparam logic [2:0] S_WR_A  = 3'd4;   // swap: second point to first slot
   localparam logic [2:0] S_WR_B  = 3'd5;   // swap: first point to second slot
   localparam logic [2:0] S_ROT   = 3'd6;   // rotate one step a cycle
   localparam logic [2:0] S_DONE  = 3'd7;   // result cycle

   function automatic logic [CB-1:0] coord_in(input logic signed [15:0] v);
      return CB'(v);
   endfunction

   function automatic logic [15:0] coord_out(input logic signed [CB-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[15:0];
   endfunction

   // control state
   logic [2:0]    state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;

   // transaction context and results
   logic [3:0]    kind_ff, kind_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] posb_ff, posb_in;
   logic [PB-1:0] probe_ff, probe_in;
   logic [PB-1:0] got_ff, got_in;     // swap: first point
   logic [PB-1:0] b_ff, b_in;         // swap: second point
   logic          swap_b_ff, swap_b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   ox_ff, ox_in;
   logic [15:0]   oy_ff, oy_in;
   logic          hit_ff, hit_in;

   // chain broadcast
   cell_op_type   cell_op;
   logic [PW-1:0] cell_pos;
   logic [PB-1:0] cell_data;

   logic [PB-1:0] pt_w      [CAPACITY];
   logic [PB-1:0] pass_pt_w [CAPACITY];
   logic          pass_hit_w[CAPACITY];

   logic [CW-1:0] occ_w, idx_w, idxb_w, pos_sel;
   logic          is_put;

   assign occ_w  = CW'(occ_ff);
   assign idx_w  = CW'(req_index);
   assign idxb_w = CW'(req_index_b);
   assign is_put = (kind_ff == K_PUSH_FRONT) || (kind_ff == K_PUSH_BACK)
                   || (kind_ff == K_INSERT);

   always_comb begin
      unique case (req_kind)
         K_PUSH_FRONT, K_POP_FRONT: pos_sel = '0;
         K_PUSH_BACK:               pos_sel = occ_w;
         K_POP_BACK:                pos_sel = occ_w - CW'(1);
         default:                   pos_sel = idx_w;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      posb_in   = posb_ff;
      probe_in  = probe_ff;
      got_in    = got_ff;
      b_in      = b_ff;
      swap_b_in = swap_b_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      hit_in    = hit_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               pos_in    = pos_sel[PW-1:0];
               posb_in   = idxb_w[PW-1:0];
               probe_in  = {coord_in(req_x), coord_in(req_y)};
               swap_b_in = 1'b0;
               cnt_in    = CW'(CAPACITY);
               status_in = ST_OK;
               ox_in     = '0;
               oy_in     = '0;
               hit_in    = 1'b0;
               state_in  = S_DONE;
               unique case (req_kind)
                  K_PUSH_FRONT, K_PUSH_BACK, K_INSERT: begin
                     if (pos_sel > occ_w) begin
                        status_in = ST_RANGE;
                     end else if (occ_w == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  K_POP_FRONT, K_POP_BACK, K_REMOVE, K_READ: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (pos_sel >= occ_w) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  K_SWAP: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if ((idx_w >= occ_w) || (idxb_w >= occ_w)) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  K_ROTATE: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (idx_w >= occ_w) begin
                        status_in = ST_RANGE;
                     end else if (idx_w != '0) begin
                        cnt_in   = idx_w;
                        state_in = S_ROT;
                     end
                  end
                  K_COLLIDE: state_in = S_SCAN;
                  K_CLEAR:   occ_in   = '0;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            unique case (kind_ff)
               K_SWAP: begin
                  if (!swap_b_ff) begin
                     got_in    = pass_pt_w[0];
                     swap_b_in = 1'b1;
                     cnt_in    = CW'(CAPACITY);
                     state_in  = S_SCAN;
                  end else begin
                     b_in     = pass_pt_w[0];
                     state_in = S_WR_A;
                  end
               end
               K_COLLIDE: begin
                  hit_in   = pass_hit_w[0];
                  state_in = S_DONE;
               end
               K_READ: begin
                  ox_in    = coord_out(pass_pt_w[0][PB-1:CB]);
                  oy_in    = coord_out(pass_pt_w[0][CB-1:0]);
                  state_in = S_DONE;
               end
               default: begin
                  // pops and remove: show the point, then close the gap
                  ox_in    = coord_out(pass_pt_w[0][PB-1:CB]);
                  oy_in    = coord_out(pass_pt_w[0][CB-1:0]);
                  state_in = S_SHIFT;
               end
            endcase
         end
         S_SHIFT: begin
            occ_in   = is_put ? occ_ff + OW'(1) : occ_ff - OW'(1);
            state_in = S_DONE;
         end
         S_WR_A: state_in = S_WR_B;
         S_WR_B: state_in = S_DONE;
         S_ROT: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // chain control
   always_comb begin
      cell_op   = CELL_HOLD;
      cell_pos  = pos_ff;
      cell_data = probe_ff;
      unique case (state_ff)
         S_SCAN:  cell_pos = swap_b_ff ? posb_ff : pos_ff;
         S_SHIFT: cell_op  = is_put ? CELL_INSERT : CELL_REMOVE;
         S_WR_A: begin
            cell_op   = CELL_WRITE;
            cell_data = b_ff;
         end
         S_WR_B: begin
            cell_op   = CELL_WRITE;
            cell_pos  = posb_ff;
            cell_data = got_ff;
         end
         S_ROT: begin
            cell_op  = CELL_ROTATE;
            cell_pos = PW'(occ_ff - OW'(1));   // tail slot takes the head
         end
         default: cell_op = CELL_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      posb_ff   <= posb_in;
      probe_ff  <= probe_in;
      got_ff    <= got_in;
      b_ff      <= b_in;
      swap_b_ff <= swap_b_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      hit_ff    <= hit_in;
   end

   // the cell chain: entry k of the list lives in cell k
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [PB-1:0] prev_pt, next_pt, next_pass_pt;
      logic          next_pass_hit;

      if (k == 0) begin : g_first
         assign prev_pt = '0;
      end else begin : g_mid
         assign prev_pt = pt_w[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign next_pt       = '0;
         assign next_pass_pt  = '0;
         assign next_pass_hit = 1'b0;
      end else begin : g_inner
         assign next_pt       = pt_w[k+1];
         assign next_pass_pt  = pass_pt_w[k+1];
         assign next_pass_hit = pass_hit_w[k+1];
      end

      plc_cell #(
         .CAPACITY   (CAPACITY),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock         (clock),
         .my_index      (PW'(k)),
         .op            (cell_op),
         .pos           (cell_pos),
         .occ           (occ_ff),
         .data          (cell_data),
         .prev_pt       (prev_pt),
         .next_pt       (next_pt),
         .head_pt       (pt_w[0]),
         .next_pass_pt  (next_pass_pt),
         .next_pass_hit (next_pass_hit),
         .pt            (pt_w[k]),
         .pass_pt       (pass_pt_w[k]),
         .pass_hit      (pass_hit_w[k])
      );
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = (state_ff == S_DONE);
   assign rsp_status  = status_ff;
   assign rsp_point_x = ox_ff;
   assign rsp_point_y = oy_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_count   = 9'(occ_ff);

endmodule

`default_nettype wire
